### src/two_stage_pll_coefficient_search_defines.svh
// Assertion macros for the PLL search checker.
`ifndef TWO_STAGE_PLL_COEFFICIENT_SEARCH_DEFINES_SVH
`define TWO_STAGE_PLL_COEFFICIENT_SEARCH_DEFINES_SVH

// same-cycle implication
`define TSPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tspcs check failed");

// next-cycle implication
`define TSPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tspcs check failed");

`endif

### src/tspcs_pkg.sv
// ----------------------------------------------------------------------------
// tspcs_pkg
// Types and constants shared by the two-stage PLL coefficient search.
// ----------------------------------------------------------------------------
package tspcs_pkg;

  localparam int TGT_W     = 20;
  localparam int FREQ_W    = 24;
  localparam int RANGE_W   = 48;
  localparam int LIM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 9;
  localparam int AIM_W     = 27;
  localparam int DIV_NUM_W = 36;
  localparam int DIV_DEN_W = 24;
  localparam int C1_W      = 32;
  localparam int C2_W      = 32;

  localparam logic [FREQ_W-1:0]  REF_RESET    = 24'd27000;
  localparam logic [RANGE_W-1:0] RANGE_RESET  = 48'hFFFFFF000001;
  localparam logic [LIM_W-1:0]   DIVLIM_RESET = 32'hFF01FF01;
  localparam logic [7:0]         DERATE_DIV   = 8'd200;

  // x / 200 == ((x >> 3) * DERATE_RECIP) >> DERATE_SHIFT for any 24-bit x
  localparam logic [21:0]        DERATE_RECIP = 22'd2684355;
  localparam int                 DERATE_SHIFT = 26;

  localparam logic [CFG_IDX_W-1:0] REG_REF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VCO1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VCO2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIM1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIM2  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE, S_HALF_WAIT, S_POST, S_VMAX_WAIT, S_M1_INIT, S_M1, S_Q1_WAIT,
    S_Q1_CHK, S_N1, S_C1_DIV, S_C1_WAIT, S_C1_CHK, S_M2, S_Q2_WAIT, S_Q2_CHK,
    S_N2_DIV, S_N2_WAIT, S_N2_CHK, S_C2_DIV, S_C2_WAIT, S_C2_CHK, S_EVAL,
    S_NEXT_M2, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_SET_HALF, CMD_P_INC, CMD_DIV_CLK, CMD_SET_VMAX,
    CMD_M1_INIT, CMD_M1_INC, CMD_DIV_Q1, CMD_SET_Q1, CMD_N1_INIT, CMD_N1_INC,
    CMD_MUL_C1, CMD_DIV_C1, CMD_SET_C1, CMD_M2_INIT, CMD_M2_INC, CMD_DIV_Q2,
    CMD_SET_Q2, CMD_MUL_N2, CMD_DIV_N2, CMD_SET_N2, CMD_FIX_C2, CMD_MUL_C2,
    CMD_DIV_C2, CMD_SET_C2, CMD_KEEP, CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic p_go;
    logic m1_end;
    logic q1_lo;
    logic q1_hi;
    logic n1_end;
    logic c1_lo;
    logic c1_hi;
    logic m2_end;
    logic q2_lo;
    logic q2_hi;
    logic n2_lo;
    logic n2_hi;
    logic fixed2;
    logic c2_lo;
    logic c2_hi;
    logic better;
    logic exact;
  } stat_t;

endpackage

### src/tspcs_if.sv
// ----------------------------------------------------------------------------
// tspcs_in_if / tspcs_out_if
// Valid/ready channels for target requests and search results.
// ----------------------------------------------------------------------------
interface tspcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [tspcs_pkg::TGT_W-1:0]  target_clock_khz;
  modport source (output valid, output target_clock_khz, input ready);
  modport sink (input valid, input target_clock_khz, output ready);
endinterface

interface tspcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [tspcs_pkg::FREQ_W-1:0] achieved_clock_khz;
  logic [7:0]                   stage1_mult;
  logic [7:0]                   stage1_div;
  logic [7:0]                   stage2_mult;
  logic [7:0]                   stage2_div;
  logic [2:0]                   post_div_log2;
  logic                         found;
  modport source (output valid, output achieved_clock_khz, output stage1_mult,
                  output stage1_div, output stage2_mult, output stage2_div,
                  output post_div_log2, output found, input ready);
  modport sink (input valid, input achieved_clock_khz, input stage1_mult,
                input stage1_div, input stage2_mult, input stage2_div,
                input post_div_log2, input found, output ready);
endinterface

### src/tspcs_divider.sv
// ----------------------------------------------------------------------------
// tspcs_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tspcs_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tspcs_pkg::DIV_NUM_W-1:0]    num,
  input  logic [tspcs_pkg::DIV_DEN_W-1:0]    den,
  output logic                               done,
  output logic [tspcs_pkg::DIV_NUM_W-1:0]    quot
);

  localparam int NW = tspcs_pkg::DIV_NUM_W;
  localparam int DW = tspcs_pkg::DIV_DEN_W;

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [5:0]    cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW+1:0] diff;

  assign shifted = {rem, quot[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      if (!diff[DW+1]) begin
        rem  <= diff[DW-1:0];
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= shifted[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

### src/tspcs_datapath.sv
// ----------------------------------------------------------------------------
// tspcs_datapath
// Config registers, loop counters, arithmetic and best-candidate tracking.
// ----------------------------------------------------------------------------
module tspcs_datapath #(
  parameter int MAX_POST_LOG2 = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tspcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tspcs_pkg::RANGE_W-1:0]       cfg_data,
  input  logic [tspcs_pkg::TGT_W-1:0]         target,
  input  tspcs_pkg::cmd_t                     cmd,
  output tspcs_pkg::stat_t                    stat,
  output logic [tspcs_pkg::FREQ_W-1:0]        achieved_clock_khz,
  output logic [7:0]                          stage1_mult,
  output logic [7:0]                          stage1_div,
  output logic [7:0]                          stage2_mult,
  output logic [7:0]                          stage2_div,
  output logic [2:0]                          post_div_log2,
  output logic                                found
);

  localparam int FW = tspcs_pkg::FREQ_W;
  localparam int NW = tspcs_pkg::DIV_NUM_W;
  localparam int CW = tspcs_pkg::CNT_W;

  logic [FW-1:0]                  ref_clk;
  logic [tspcs_pkg::RANGE_W-1:0]  vco1, vco2, in1, in2;
  logic [tspcs_pkg::LIM_W-1:0]    lim1, lim2;

  logic [tspcs_pkg::TGT_W-1:0]    tgt;
  logic [2:0]                     p;
  logic [tspcs_pkg::AIM_W-1:0]    aim;
  logic [FW-1:0]                  half;
  logic [FW-1:0]                  vmax2e;
  logic [CW-1:0]                  m1, n1, m2;
  logic [FW-1:0]                  q1, q2;
  logic [tspcs_pkg::C1_W-1:0]     c1;
  logic [NW-1:0]                  n2;
  logic [tspcs_pkg::C2_W-1:0]     c2;
  logic [NW-1:0]                  prod;
  logic                           have;
  logic [tspcs_pkg::C2_W-1:0]     bdelta;
  logic [FW-1:0]                  bclk;
  logic [7:0]                     bn1, bm1, bn2, bm2;
  logic [2:0]                     bp;

  logic [FW-1:0] vmin1, vmax1, vmin2, vmax2, umin1, umax1, umin2, umax2;
  logic [7:0]    m1lo, m1hi, n1lo, n1hi, m2lo, m2hi, n2lo, n2hi;
  logic [tspcs_pkg::C2_W-1:0] co, d;
  logic [20:0]   raised;

  logic                  div_start;
  logic [NW-1:0]         div_num;
  logic [FW-1:0]         div_den;
  logic                  div_done;
  logic [NW-1:0]         div_quot;

  // divide by 200 through a reciprocal multiply
  function automatic logic [FW-1:0] div200(logic [FW-1:0] x);
    logic [42:0] scaled;
    scaled = 43'(x[FW-1:3]) * 43'(tspcs_pkg::DERATE_RECIP);
    return FW'(scaled[42:tspcs_pkg::DERATE_SHIFT]);
  endfunction

  assign vmin1 = (vco1[FW-1:0] == '0) ? FW'(1) : vco1[FW-1:0];
  assign vmax1 = vco1[2*FW-1:FW];
  assign vmin2 = (vco2[FW-1:0] == '0) ? FW'(1) : vco2[FW-1:0];
  assign vmax2 = vco2[2*FW-1:FW];
  assign umin1 = in1[FW-1:0];
  assign umax1 = in1[2*FW-1:FW];
  assign umin2 = in2[FW-1:0];
  assign umax2 = in2[2*FW-1:FW];
  assign m1lo  = (lim1[7:0] == 8'd0) ? 8'd1 : lim1[7:0];
  assign m1hi  = lim1[15:8];
  assign n1lo  = lim1[23:16];
  assign n1hi  = lim1[31:24];
  assign m2lo  = (lim2[7:0] == 8'd0) ? 8'd1 : lim2[7:0];
  assign m2hi  = lim2[15:8];
  assign n2lo  = lim2[23:16];
  assign n2hi  = lim2[31:24];

  assign co     = c2 >> p;
  assign d      = (co >= 32'(tgt)) ? co - 32'(tgt) : 32'(tgt) - co;
  assign raised = 21'(tgt) + 21'(div200(FW'(tgt)));

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd)
      tspcs_pkg::CMD_DIV_Q1: begin
        div_num = NW'(ref_clk);
        div_den = FW'(m1[7:0]);
      end
      tspcs_pkg::CMD_DIV_C1: begin
        div_num = prod;
        div_den = FW'(m1[7:0]);
      end
      tspcs_pkg::CMD_DIV_Q2: begin
        div_num = NW'(c1[FW-1:0]);
        div_den = FW'(m2[7:0]);
      end
      tspcs_pkg::CMD_DIV_N2: begin
        div_num = prod;
        div_den = c1[FW-1:0];
      end
      tspcs_pkg::CMD_DIV_C2: begin
        div_num = prod;
        div_den = FW'(m2[7:0]);
      end
      default: div_start = 1'b0;
    endcase
  end

  tspcs_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    stat.div_done = div_done;
    stat.p_go     = (tgt != '0) && (p < 3'(MAX_POST_LOG2)) &&
                    (FW'(tgt) <= (half >> p));
    stat.m1_end   = m1 > CW'(m1hi);
    stat.q1_lo    = q1 < umin1;
    stat.q1_hi    = q1 > umax1;
    stat.n1_end   = n1 > CW'(n1hi);
    stat.c1_lo    = c1 < 32'(vmin1);
    stat.c1_hi    = c1 > 32'(vmax1);
    stat.m2_end   = m2 > CW'(m2hi);
    stat.q2_lo    = q2 < umin2;
    stat.q2_hi    = q2 > umax2;
    stat.n2_lo    = n2 < NW'(n2lo);
    stat.n2_hi    = n2 > NW'(n2hi);
    stat.fixed2   = (m2lo == m2hi) && (n2lo == n2hi);
    stat.c2_lo    = c2 < 32'(vmin2);
    stat.c2_hi    = c2 > 32'(vmax2e);
    stat.better   = !have || (d < bdelta);
    stat.exact    = d == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clk <= tspcs_pkg::REF_RESET;
      vco1    <= tspcs_pkg::RANGE_RESET;
      vco2    <= tspcs_pkg::RANGE_RESET;
      in1     <= tspcs_pkg::RANGE_RESET;
      in2     <= tspcs_pkg::RANGE_RESET;
      lim1    <= tspcs_pkg::DIVLIM_RESET;
      lim2    <= tspcs_pkg::DIVLIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tspcs_pkg::REG_REF:  ref_clk <= cfg_data[FW-1:0];
        tspcs_pkg::REG_VCO1: vco1    <= cfg_data;
        tspcs_pkg::REG_VCO2: vco2    <= cfg_data;
        tspcs_pkg::REG_IN1:  in1     <= cfg_data;
        tspcs_pkg::REG_IN2:  in2     <= cfg_data;
        tspcs_pkg::REG_LIM1: lim1    <= cfg_data[tspcs_pkg::LIM_W-1:0];
        tspcs_pkg::REG_LIM2: lim2    <= cfg_data[tspcs_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd == tspcs_pkg::CMD_LOAD) begin
      have <= 1'b0;
    end else if (cmd == tspcs_pkg::CMD_KEEP) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      tspcs_pkg::CMD_LOAD: begin
        tgt <= target;
        p   <= 3'd0;
      end
      tspcs_pkg::CMD_SET_HALF: half <= (vmax2 - div200(vmax2)) >> 1;
      tspcs_pkg::CMD_P_INC:    p <= p + 3'd1;
      tspcs_pkg::CMD_DIV_CLK:  aim <= tspcs_pkg::AIM_W'(tgt) << p;
      tspcs_pkg::CMD_SET_VMAX: vmax2e <= (vmax2 < FW'(raised)) ? FW'(raised) : vmax2;
      tspcs_pkg::CMD_M1_INIT:  m1 <= CW'(m1lo);
      tspcs_pkg::CMD_M1_INC:   m1 <= m1 + CW'(1);
      tspcs_pkg::CMD_SET_Q1:   q1 <= div_quot[FW-1:0];
      tspcs_pkg::CMD_N1_INIT:  n1 <= CW'(n1lo);
      tspcs_pkg::CMD_N1_INC:   n1 <= n1 + CW'(1);
      tspcs_pkg::CMD_MUL_C1:   prod <= NW'(ref_clk * n1[7:0]);
      tspcs_pkg::CMD_SET_C1:   c1 <= div_quot[tspcs_pkg::C1_W-1:0];
      tspcs_pkg::CMD_M2_INIT:  m2 <= CW'(m2lo);
      tspcs_pkg::CMD_M2_INC:   m2 <= m2 + CW'(1);
      tspcs_pkg::CMD_SET_Q2:   q2 <= div_quot[FW-1:0];
      tspcs_pkg::CMD_MUL_N2:   prod <= NW'(aim * m2[7:0]) + NW'(c1[FW-1:1]);
      tspcs_pkg::CMD_SET_N2:   n2 <= div_quot;
      tspcs_pkg::CMD_FIX_C2:   c2 <= c1;
      tspcs_pkg::CMD_MUL_C2:   prod <= NW'(c1[FW-1:0] * n2[7:0]);
      tspcs_pkg::CMD_SET_C2:   c2 <= div_quot[tspcs_pkg::C2_W-1:0];
      tspcs_pkg::CMD_KEEP: begin
        bdelta <= d;
        bclk   <= co[FW-1:0];
        bn1    <= n1[7:0];
        bm1    <= m1[7:0];
        bn2    <= n2[7:0];
        bm2    <= m2[7:0];
        bp     <= p;
      end
      tspcs_pkg::CMD_OUT: begin
        if (!have || bclk == '0) begin
          achieved_clock_khz <= '0;
          stage1_mult        <= '0;
          stage1_div         <= '0;
          stage2_mult        <= '0;
          stage2_div         <= '0;
          post_div_log2      <= '0;
          found              <= 1'b0;
        end else begin
          achieved_clock_khz <= bclk;
          stage1_mult        <= bn1;
          stage1_div         <= bm1;
          stage2_mult        <= bn2;
          stage2_div         <= bm2;
          post_div_log2      <= bp;
          found              <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### src/tspcs_ctrl.sv
// ----------------------------------------------------------------------------
// tspcs_ctrl
// Sequencer for the M1 / N1 / M2 search and the request handshakes.
// ----------------------------------------------------------------------------
module tspcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tspcs_pkg::stat_t  stat,
  output tspcs_pkg::cmd_t   cmd
);

  tspcs_pkg::state_t state, state_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tspcs_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = tspcs_pkg::CMD_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      tspcs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = tspcs_pkg::CMD_LOAD;
          state_next = tspcs_pkg::S_HALF_WAIT;
        end
      end
      tspcs_pkg::S_HALF_WAIT: begin
        cmd        = tspcs_pkg::CMD_SET_HALF;
        state_next = tspcs_pkg::S_POST;
      end
      tspcs_pkg::S_POST: begin
        if (stat.p_go) begin
          cmd = tspcs_pkg::CMD_P_INC;
        end else begin
          cmd        = tspcs_pkg::CMD_DIV_CLK;
          state_next = tspcs_pkg::S_VMAX_WAIT;
        end
      end
      tspcs_pkg::S_VMAX_WAIT: begin
        cmd        = tspcs_pkg::CMD_SET_VMAX;
        state_next = tspcs_pkg::S_M1_INIT;
      end
      tspcs_pkg::S_M1_INIT: begin
        cmd        = tspcs_pkg::CMD_M1_INIT;
        state_next = tspcs_pkg::S_M1;
      end
      tspcs_pkg::S_M1: begin
        if (stat.m1_end) begin
          state_next = tspcs_pkg::S_FIN;
        end else begin
          cmd        = tspcs_pkg::CMD_DIV_Q1;
          state_next = tspcs_pkg::S_Q1_WAIT;
        end
      end
      tspcs_pkg::S_Q1_WAIT: begin
        if (stat.div_done) begin
          cmd        = tspcs_pkg::CMD_SET_Q1;
          state_next = tspcs_pkg::S_Q1_CHK;
        end
      end
      tspcs_pkg::S_Q1_CHK: begin
        if (stat.q1_lo) begin
          state_next = tspcs_pkg::S_FIN;
        end else if (stat.q1_hi) begin
          cmd        = tspcs_pkg::CMD_M1_INC;
          state_next = tspcs_pkg::S_M1;
        end else begin
          cmd        = tspcs_pkg::CMD_N1_INIT;
          state_next = tspcs_pkg::S_N1;
        end
      end
      tspcs_pkg::S_N1: begin
        if (stat.n1_end) begin
          cmd        = tspcs_pkg::CMD_M1_INC;
          state_next = tspcs_pkg::S_M1;
        end else begin
          cmd        = tspcs_pkg::CMD_MUL_C1;
          state_next = tspcs_pkg::S_C1_DIV;
        end
      end
      tspcs_pkg::S_C1_DIV: begin
        cmd        = tspcs_pkg::CMD_DIV_C1;
        state_next = tspcs_pkg::S_C1_WAIT;
      end
      tspcs_pkg::S_C1_WAIT: begin
        if (stat.div_done) begin
          cmd        = tspcs_pkg::CMD_SET_C1;
          state_next = tspcs_pkg::S_C1_CHK;
        end
      end
      tspcs_pkg::S_C1_CHK: begin
        if (stat.c1_lo) begin
          cmd        = tspcs_pkg::CMD_N1_INC;
          state_next = tspcs_pkg::S_N1;
        end else if (stat.c1_hi) begin
          cmd        = tspcs_pkg::CMD_M1_INC;
          state_next = tspcs_pkg::S_M1;
        end else begin
          cmd        = tspcs_pkg::CMD_M2_INIT;
          state_next = tspcs_pkg::S_M2;
        end
      end
      tspcs_pkg::S_M2: begin
        if (stat.m2_end) begin
          cmd        = tspcs_pkg::CMD_N1_INC;
          state_next = tspcs_pkg::S_N1;
        end else begin
          cmd        = tspcs_pkg::CMD_DIV_Q2;
          state_next = tspcs_pkg::S_Q2_WAIT;
        end
      end
      tspcs_pkg::S_Q2_WAIT: begin
        if (stat.div_done) begin
          cmd        = tspcs_pkg::CMD_SET_Q2;
          state_next = tspcs_pkg::S_Q2_CHK;
        end
      end
      tspcs_pkg::S_Q2_CHK: begin
        if (stat.q2_lo) begin
          cmd        = tspcs_pkg::CMD_N1_INC;
          state_next = tspcs_pkg::S_N1;
        end else if (stat.q2_hi) begin
          cmd        = tspcs_pkg::CMD_M2_INC;
          state_next = tspcs_pkg::S_M2;
        end else begin
          cmd        = tspcs_pkg::CMD_MUL_N2;
          state_next = tspcs_pkg::S_N2_DIV;
        end
      end
      tspcs_pkg::S_N2_DIV: begin
        cmd        = tspcs_pkg::CMD_DIV_N2;
        state_next = tspcs_pkg::S_N2_WAIT;
      end
      tspcs_pkg::S_N2_WAIT: begin
        if (stat.div_done) begin
          cmd        = tspcs_pkg::CMD_SET_N2;
          state_next = tspcs_pkg::S_N2_CHK;
        end
      end
      tspcs_pkg::S_N2_CHK: begin
        if (stat.n2_lo) begin
          cmd        = tspcs_pkg::CMD_M2_INC;
          state_next = tspcs_pkg::S_M2;
        end else if (stat.n2_hi) begin
          cmd        = tspcs_pkg::CMD_N1_INC;
          state_next = tspcs_pkg::S_N1;
        end else if (stat.fixed2) begin
          cmd        = tspcs_pkg::CMD_FIX_C2;
          state_next = tspcs_pkg::S_EVAL;
        end else begin
          cmd        = tspcs_pkg::CMD_MUL_C2;
          state_next = tspcs_pkg::S_C2_DIV;
        end
      end
      tspcs_pkg::S_C2_DIV: begin
        cmd        = tspcs_pkg::CMD_DIV_C2;
        state_next = tspcs_pkg::S_C2_WAIT;
      end
      tspcs_pkg::S_C2_WAIT: begin
        if (stat.div_done) begin
          cmd        = tspcs_pkg::CMD_SET_C2;
          state_next = tspcs_pkg::S_C2_CHK;
        end
      end
      tspcs_pkg::S_C2_CHK: begin
        if (stat.c2_lo) begin
          cmd        = tspcs_pkg::CMD_N1_INC;
          state_next = tspcs_pkg::S_N1;
        end else if (stat.c2_hi) begin
          cmd        = tspcs_pkg::CMD_M2_INC;
          state_next = tspcs_pkg::S_M2;
        end else begin
          state_next = tspcs_pkg::S_EVAL;
        end
      end
      tspcs_pkg::S_EVAL: begin
        if (stat.better) begin
          cmd        = tspcs_pkg::CMD_KEEP;
          state_next = stat.exact ? tspcs_pkg::S_FIN : tspcs_pkg::S_NEXT_M2;
        end else begin
          cmd        = tspcs_pkg::CMD_M2_INC;
          state_next = tspcs_pkg::S_M2;
        end
      end
      tspcs_pkg::S_NEXT_M2: begin
        cmd        = tspcs_pkg::CMD_M2_INC;
        state_next = tspcs_pkg::S_M2;
      end
      tspcs_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd            = tspcs_pkg::CMD_OUT;
          out_valid_next = 1'b1;
          state_next     = tspcs_pkg::S_IDLE;
        end
      end
      default: state_next = tspcs_pkg::S_IDLE;
    endcase
  end

endmodule

### src/two_stage_pll_coefficient_search.sv
// Operation: setup steps pick the post divider, then the search walks the M1
//   values, N1 values and M2 candidates; every division runs on the shared
//   serial divider. The result register loads in S_FIN once any earlier result is taken.
// Throughput: one request at a time; the next is taken once the result is
//   in the output register, while that result may still wait to be taken.
// Reset: synchronous, active high; config registers return to their defaults.
// ----------------------------------------------------------------------------
// two_stage_pll_coefficient_search
// Finds two-stage PLL divider settings closest to a requested pixel clock.
// ----------------------------------------------------------------------------
module two_stage_pll_coefficient_search #(
  parameter int MAX_POST_LOG2 = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tspcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tspcs_pkg::RANGE_W-1:0]     cfg_data,
  tspcs_in_if.sink                          in_ch,
  tspcs_out_if.source                       out_ch
);

  tspcs_pkg::cmd_t  cmd;
  tspcs_pkg::stat_t stat;

  tspcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tspcs_datapath #(
    .MAX_POST_LOG2 (MAX_POST_LOG2)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .target             (in_ch.target_clock_khz),
    .cmd                (cmd),
    .stat               (stat),
    .achieved_clock_khz (out_ch.achieved_clock_khz),
    .stage1_mult        (out_ch.stage1_mult),
    .stage1_div         (out_ch.stage1_div),
    .stage2_mult        (out_ch.stage2_mult),
    .stage2_div         (out_ch.stage2_div),
    .post_div_log2      (out_ch.post_div_log2),
    .found              (out_ch.found)
  );

endmodule

### src/tspcs_checker.sv
// ----------------------------------------------------------------------------
// tspcs_checker
// Port-level checks on the PLL search block.
// ----------------------------------------------------------------------------
`include "two_stage_pll_coefficient_search_defines.svh"

module tspcs_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] achieved,
  input logic [7:0]  n1,
  input logic [7:0]  m1,
  input logic [2:0]  post,
  input logic        found
);

`TSPCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
`TSPCS_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
`TSPCS_ASSERT_NOW(a_found_match, out_valid, found == (achieved != 24'd0))
`TSPCS_ASSERT_NOW(a_none_zero, out_valid && !found, n1 == 8'd0 && m1 == 8'd0 && post == 3'd0)

endmodule

bind two_stage_pll_coefficient_search tspcs_props u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .achieved  (out_ch.achieved_clock_khz),
  .n1        (out_ch.stage1_mult),
  .m1        (out_ch.stage1_div),
  .post      (out_ch.post_div_log2),
  .found     (out_ch.found)
);
